// ===== rtl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper package
// Shared types, codes and calendar arithmetic for the date stepper block.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int YEAR_W          = 14;
    localparam int MONTH_W         = 4;
    localparam int DAY_W           = 5;
    localparam int IVL_W           = 23;
    localparam int CNT_IN_W        = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CUM_W           = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_MIN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_MIN   = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_MAX   = DAY_W'(31);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_BACK    = 2'd2,
        OP_MEASURE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_STEP_FWD,
        S_STEP_BACK,
        S_MEASURE,
        S_FINISH
    } t_state;

    // terms summed into a day number, in sequencer order
    typedef enum logic [2:0] {
        TERM_YEARS,
        TERM_QUAD,
        TERM_CENT,
        TERM_QUADCENT,
        TERM_MONTHDAY
    } t_term;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic clear;
        logic en;
        logic sub;
    } t_acc_ctl;

    // floor(x / 25) by reciprocal, exact for all 12-bit x
    function automatic logic [7:0] div25(input logic [11:0] x);
        logic [24:0] prod;
        prod = 25'(x) * 25'(13'd5243);
        return prod[24:17];
    endfunction

    function automatic logic mod25_zero(input logic [11:0] x);
        logic [12:0] back;
        back = 13'(div25(x)) * 13'd25;
        return back == {1'b0, x};
    endfunction

    // divisible by 100 means divisible by 4 with quarter divisible by 25
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic by4;
        logic by100;
        logic by400;
        by4   = (y[1:0] == 2'b00);
        by100 = by4 && mod25_zero(y[13:2]);
        by400 = (y[3:0] == 4'b0000) && mod25_zero({2'b00, y[13:4]});
        return (by4 && !by100) || by400;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                     len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11:  len = DAY_W'(30);
            default:                  len = DAY_W'(31);
        endcase
        return len;
    endfunction

    // days in the year before the first of month m
    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [CUM_W-1:0] base;
        case (m)
            4'd2:    base = CUM_W'(31);
            4'd3:    base = CUM_W'(59);
            4'd4:    base = CUM_W'(90);
            4'd5:    base = CUM_W'(120);
            4'd6:    base = CUM_W'(151);
            4'd7:    base = CUM_W'(181);
            4'd8:    base = CUM_W'(212);
            4'd9:    base = CUM_W'(243);
            4'd10:   base = CUM_W'(273);
            4'd11:   base = CUM_W'(304);
            4'd12:   base = CUM_W'(334);
            default: base = CUM_W'(0);
        endcase
        return base + CUM_W'(leap && (m > MONTH_W'(2)));
    endfunction

endpackage

// ===== rtl/cds_if.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface cds_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic [cds_pkg::CNT_IN_W-1:0]    day_count;
    logic [cds_pkg::YEAR_W-1:0]      target_year;
    logic [cds_pkg::MONTH_W-1:0]     target_month;
    logic [cds_pkg::DAY_W-1:0]       target_day;

    modport source (
        output valid, operation, day_count, target_year, target_month, target_day,
        input  ready
    );
    modport sink (
        input  valid, operation, day_count, target_year, target_month, target_day,
        output ready
    );
endinterface

interface cds_out_if;
    logic                            valid;
    logic                            ready;
    logic [cds_pkg::YEAR_W-1:0]      current_year;
    logic [cds_pkg::MONTH_W-1:0]     current_month;
    logic [cds_pkg::DAY_W-1:0]       current_day;
    logic signed [cds_pkg::IVL_W-1:0] day_interval;
    logic                            range_hit;

    modport source (
        output valid, current_year, current_month, current_day, day_interval, range_hit,
        input  ready
    );
    modport sink (
        input  valid, current_year, current_month, current_day, day_interval, range_hit,
        output ready
    );
endinterface

// ===== rtl/cds_step.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper: one-day step unit
// Gives the next or previous calendar date and flags the range limits.
// ----------------------------------------------------------------------------
module cds_step (
    input  cds_pkg::t_date i_date,
    input  logic           i_back,
    output cds_pkg::t_date o_next,
    output logic           o_at_limit
);

    logic                           leap;
    logic [cds_pkg::DAY_W-1:0]      len_cur;
    logic [cds_pkg::DAY_W-1:0]      len_prev;
    logic [cds_pkg::MONTH_W-1:0]    month_prev;

    assign leap       = cds_pkg::leap_year(i_date.year);
    assign month_prev = i_date.month - cds_pkg::MONTH_W'(1);
    assign len_cur    = cds_pkg::month_len(i_date.month, leap);
    assign len_prev   = cds_pkg::month_len(month_prev, leap);

    always_comb begin
        o_next = i_date;
        if (i_back) begin
            o_at_limit = (i_date.year == cds_pkg::YEAR_MIN) &&
                         (i_date.month == cds_pkg::MONTH_MIN) &&
                         (i_date.day == cds_pkg::DAY_MIN);
            if (i_date.day > cds_pkg::DAY_MIN) begin
                o_next.day = i_date.day - cds_pkg::DAY_W'(1);
            end else if (i_date.month > cds_pkg::MONTH_MIN) begin
                o_next.month = month_prev;
                o_next.day   = len_prev;
            end else begin
                // wrap to the last day of the previous year
                o_next.year  = i_date.year - cds_pkg::YEAR_W'(1);
                o_next.month = cds_pkg::MONTH_MAX;
                o_next.day   = cds_pkg::DAY_MAX;
            end
        end else begin
            o_at_limit = (i_date.year == cds_pkg::YEAR_MAX) &&
                         (i_date.month == cds_pkg::MONTH_MAX) &&
                         (i_date.day == cds_pkg::DAY_MAX);
            if (i_date.day < len_cur) begin
                o_next.day = i_date.day + cds_pkg::DAY_W'(1);
            end else if (i_date.month < cds_pkg::MONTH_MAX) begin
                o_next.month = i_date.month + cds_pkg::MONTH_W'(1);
                o_next.day   = cds_pkg::DAY_MIN;
            end else begin
                o_next.year  = i_date.year + cds_pkg::YEAR_W'(1);
                o_next.month = cds_pkg::MONTH_MIN;
                o_next.day   = cds_pkg::DAY_MIN;
            end
        end
    end

endmodule

// ===== rtl/cds_term.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper: day number term generator
// Produces one term of a date's day number counted from 0001-01-01.
// ----------------------------------------------------------------------------
module cds_term (
    input  cds_pkg::t_date              i_date,
    input  cds_pkg::t_term              i_sel,
    output logic [cds_pkg::IVL_W-1:0]   o_term
);

    logic [cds_pkg::YEAR_W-1:0] prior;
    logic                       leap;
    logic [cds_pkg::CUM_W-1:0]  cum;

    // whole years before the date
    assign prior = i_date.year - cds_pkg::YEAR_W'(1);
    assign leap  = cds_pkg::leap_year(i_date.year);
    assign cum   = cds_pkg::cum_days(i_date.month, leap);

    always_comb begin
        unique case (i_sel)
            cds_pkg::TERM_YEARS:
                o_term = cds_pkg::IVL_W'(prior) * cds_pkg::IVL_W'(365);
            cds_pkg::TERM_QUAD:
                o_term = cds_pkg::IVL_W'(prior[13:2]);
            cds_pkg::TERM_CENT:
                o_term = cds_pkg::IVL_W'(cds_pkg::div25(prior[13:2]));
            cds_pkg::TERM_QUADCENT:
                o_term = cds_pkg::IVL_W'(cds_pkg::div25({2'b00, prior[13:4]}));
            cds_pkg::TERM_MONTHDAY:
                o_term = cds_pkg::IVL_W'(cum) + cds_pkg::IVL_W'(i_date.day)
                       - cds_pkg::IVL_W'(1);
            default:
                o_term = '0;
        endcase
    end

endmodule

// ===== rtl/cds_accum.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper: shared accumulator
// Clears, or adds or subtracts one term per cycle when enabled, into a wrapping interval register.
// ----------------------------------------------------------------------------
module cds_accum (
    input  logic                        i_clk,
    input  cds_pkg::t_acc_ctl           i_ctl,
    input  logic [cds_pkg::IVL_W-1:0]   i_term,
    output logic [cds_pkg::IVL_W-1:0]   o_acc
);

    logic [cds_pkg::IVL_W-1:0] r_acc;
    logic [cds_pkg::IVL_W-1:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.en) begin
            n_acc = i_ctl.sub ? (r_acc - i_term) : (r_acc + i_term);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/calendar_date_stepper.sv =====
// Sequence: load passes through the clamp and finish states; advance and go back
//   step one day per cycle through the shared step unit between them; measure
//   sums ten terms by the shared accumulator. Throughput: one item at a time,
//   next item taken once the block returns to idle.
// Reset: synchronous active low; date set to 1901-01-01, sequencer idle,
//   no result pending.
// ----------------------------------------------------------------------------
// Calendar date stepper
// Holds a Gregorian date; loads, steps it by days, or measures an interval.
// ----------------------------------------------------------------------------
module calendar_date_stepper #(
    parameter int COUNT_WIDTH = cds_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cds_in_if.sink     i_in,
    cds_out_if.source  o_out
);

    localparam int CntIn = (COUNT_WIDTH < cds_pkg::CNT_IN_W) ? COUNT_WIDTH
                                                             : cds_pkg::CNT_IN_W;

    cds_pkg::t_state                  r_state, n_state;
    cds_pkg::t_op                     r_op, n_op;
    logic [COUNT_WIDTH-1:0]           r_cnt, n_cnt;
    cds_pkg::t_date                   r_raw, n_raw;
    cds_pkg::t_date                   r_tgt, n_tgt;
    cds_pkg::t_date                   r_date, n_date;
    logic                             r_hit, n_hit;
    cds_pkg::t_term                   r_sel, n_sel;
    logic                             r_pass, n_pass;
    logic                             r_out_valid, n_out_valid;
    cds_pkg::t_date                   r_out_date, n_out_date;
    logic [cds_pkg::IVL_W-1:0]        r_out_ivl, n_out_ivl;
    logic                             r_out_hit, n_out_hit;

    cds_pkg::t_date                   clamped;
    logic [cds_pkg::DAY_W-1:0]        clamp_len;
    cds_pkg::t_date                   step_next;
    logic                             step_limit;
    cds_pkg::t_date                   term_date;
    logic [cds_pkg::IVL_W-1:0]        term;
    cds_pkg::t_acc_ctl                acc_ctl;
    logic [cds_pkg::IVL_W-1:0]        acc;

    // clamp target field by field: year, then month, then day
    always_comb begin
        clamped = r_raw;
        if (r_raw.year < cds_pkg::YEAR_MIN) begin
            clamped.year = cds_pkg::YEAR_MIN;
        end else if (r_raw.year > cds_pkg::YEAR_MAX) begin
            clamped.year = cds_pkg::YEAR_MAX;
        end
        if (r_raw.month < cds_pkg::MONTH_MIN) begin
            clamped.month = cds_pkg::MONTH_MIN;
        end else if (r_raw.month > cds_pkg::MONTH_MAX) begin
            clamped.month = cds_pkg::MONTH_MAX;
        end
        clamp_len = cds_pkg::month_len(clamped.month, cds_pkg::leap_year(clamped.year));
        if (r_raw.day < cds_pkg::DAY_MIN) begin
            clamped.day = cds_pkg::DAY_MIN;
        end else if (r_raw.day > clamp_len) begin
            clamped.day = clamp_len;
        end
    end

    cds_step u_step (
        .i_date     (r_date),
        .i_back     (r_state == cds_pkg::S_STEP_BACK),
        .o_next     (step_next),
        .o_at_limit (step_limit)
    );

    assign term_date = r_pass ? r_date : r_tgt;

    cds_term u_term (
        .i_date (term_date),
        .i_sel  (r_sel),
        .o_term (term)
    );

    cds_accum u_accum (
        .i_clk  (i_clk),
        .i_ctl  (acc_ctl),
        .i_term (term),
        .o_acc  (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cds_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_date      <= '{year: cds_pkg::YEAR_W'(1901), month: cds_pkg::MONTH_MIN,
                             day: cds_pkg::DAY_MIN};
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_date      <= n_date;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_cnt      <= n_cnt;
        r_raw      <= n_raw;
        r_tgt      <= n_tgt;
        r_hit      <= n_hit;
        r_sel      <= n_sel;
        r_pass     <= n_pass;
        r_out_date <= n_out_date;
        r_out_ivl  <= n_out_ivl;
        r_out_hit  <= n_out_hit;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_raw       = r_raw;
        n_tgt       = r_tgt;
        n_date      = r_date;
        n_hit       = r_hit;
        n_sel       = r_sel;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_date  = r_out_date;
        n_out_ivl   = r_out_ivl;
        n_out_hit   = r_out_hit;
        acc_ctl     = '{clear: 1'b0, en: 1'b0, sub: 1'b0};

        unique case (r_state)
            cds_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op        = cds_pkg::t_op'(i_in.operation);
                    n_cnt       = COUNT_WIDTH'(i_in.day_count[CntIn-1:0]);
                    n_raw.year  = i_in.target_year;
                    n_raw.month = i_in.target_month;
                    n_raw.day   = i_in.target_day;
                    n_state     = cds_pkg::S_CLAMP;
                end
            end
            cds_pkg::S_CLAMP: begin
                n_tgt         = clamped;
                n_hit         = 1'b0;
                n_sel         = cds_pkg::TERM_YEARS;
                n_pass        = 1'b0;
                acc_ctl.clear = 1'b1;
                unique case (r_op)
                    cds_pkg::OP_LOAD: begin
                        n_date  = clamped;
                        n_state = cds_pkg::S_FINISH;
                    end
                    cds_pkg::OP_ADVANCE: n_state = cds_pkg::S_STEP_FWD;
                    cds_pkg::OP_BACK:    n_state = cds_pkg::S_STEP_BACK;
                    cds_pkg::OP_MEASURE: n_state = cds_pkg::S_MEASURE;
                    default:             n_state = cds_pkg::S_FINISH;
                endcase
            end
            cds_pkg::S_STEP_FWD, cds_pkg::S_STEP_BACK: begin
                if (r_cnt == '0) begin
                    n_state = cds_pkg::S_FINISH;
                end else if (step_limit) begin
                    // stop at the range limit with days still to go
                    n_hit   = 1'b1;
                    n_state = cds_pkg::S_FINISH;
                end else begin
                    n_date = step_next;
                    n_cnt  = r_cnt - COUNT_WIDTH'(1);
                end
            end
            cds_pkg::S_MEASURE: begin
                // target terms add, stored date terms subtract; centuries negate
                acc_ctl.en  = 1'b1;
                acc_ctl.sub = r_pass ^ (r_sel == cds_pkg::TERM_CENT);
                unique case (r_sel)
                    cds_pkg::TERM_YEARS:    n_sel = cds_pkg::TERM_QUAD;
                    cds_pkg::TERM_QUAD:     n_sel = cds_pkg::TERM_CENT;
                    cds_pkg::TERM_CENT:     n_sel = cds_pkg::TERM_QUADCENT;
                    cds_pkg::TERM_QUADCENT: n_sel = cds_pkg::TERM_MONTHDAY;
                    default: begin
                        n_sel  = cds_pkg::TERM_YEARS;
                        n_pass = 1'b1;
                        if (r_pass) begin
                            n_state = cds_pkg::S_FINISH;
                        end
                    end
                endcase
            end
            cds_pkg::S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_date  = r_date;
                    n_out_ivl   = (r_op == cds_pkg::OP_MEASURE) ? acc : '0;
                    n_out_hit   = r_hit;
                    n_state     = cds_pkg::S_IDLE;
                end
            end
            default: n_state = cds_pkg::S_IDLE;
        endcase
    end

    assign i_in.ready          = (r_state == cds_pkg::S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.current_year  = r_out_date.year;
    assign o_out.current_month = r_out_date.month;
    assign o_out.current_day   = r_out_date.day;
    assign o_out.day_interval  = r_out_ivl;
    assign o_out.range_hit     = r_out_hit;

`ifndef SYNTHESIS
    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_date.month >= cds_pkg::MONTH_MIN) && (r_date.month <= cds_pkg::MONTH_MAX) &&
        (r_date.day >= cds_pkg::DAY_MIN) && (r_date.year >= cds_pkg::YEAR_MIN) &&
        (r_date.year <= cds_pkg::YEAR_MAX))
        else $error("stored date out of range");

    a_hit_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.range_hit) |->
        ((o_out.current_year == cds_pkg::YEAR_MAX) &&
         (o_out.current_month == cds_pkg::MONTH_MAX) &&
         (o_out.current_day == cds_pkg::DAY_MAX)) ||
        ((o_out.current_year == cds_pkg::YEAR_MIN) &&
         (o_out.current_month == cds_pkg::MONTH_MIN) &&
         (o_out.current_day == cds_pkg::DAY_MIN)))
        else $error("range flag without limit date");

    a_measure_keeps_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cds_pkg::S_MEASURE) |=> $stable(r_date))
        else $error("date changed during interval measurement");

    a_ivl_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.day_interval != '0)) |-> !o_out.range_hit)
        else $error("interval and range flag both set");
`endif

endmodule

// ===== dv/calendar_date_stepper_tb.sv =====
// ----------------------------------------------------------------------------
// Calendar date stepper testbench
// Drives load, advance, go-back and measure commands through the valid/ready
// channels and checks each result against a date predictor in a scoreboard.
// Covers calendar limits, leap rules and target clamping, then random traffic
// under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module calendar_date_stepper_tb;

    localparam int LAST_DAY_NUMBER = 3652058;   // 9999-12-31 counted from 0001-01-01

    typedef struct {
        cds_pkg::t_op                      op;
        logic [cds_pkg::CNT_IN_W-1:0]      count;
        logic [cds_pkg::YEAR_W-1:0]        year;
        logic [cds_pkg::MONTH_W-1:0]       month;
        logic [cds_pkg::DAY_W-1:0]         day;
    } t_date_cmd;

    typedef struct {
        logic [cds_pkg::YEAR_W-1:0]        year;
        logic [cds_pkg::MONTH_W-1:0]       month;
        logic [cds_pkg::DAY_W-1:0]         day;
        logic signed [cds_pkg::IVL_W-1:0]  interval;
        logic                              hit;
    } t_date_res;

    class t_date_scoreboard;
        int        year;
        int        month;
        int        day;
        int        errors;
        t_date_res pending[$];

        function new();
            year   = 1901;
            month  = 1;
            day    = 1;
            errors = 0;
        endfunction

        function bit is_leap_year(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int days_of_month(int y, int m);
            case (m)
                2:           return is_leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function int day_number(int y, int m, int d);
            int p;
            int n;
            p = y - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400;
            for (int k = 1; k < m; k++)
                n += days_of_month(y, k);
            return n + d - 1;
        endfunction

        // split a day number into 400-, 100-, 4- and 1-year cycles
        function void set_from_number(int n);
            int q400;
            int q100;
            int q4;
            int q1;
            int rem;
            int y;
            int m;
            q400 = n / 146097;
            rem  = n % 146097;
            q100 = rem / 36524;
            if (q100 > 3) q100 = 3;
            rem -= q100 * 36524;
            q4   = rem / 1461;
            rem  = rem % 1461;
            q1   = rem / 365;
            if (q1 > 3) q1 = 3;
            rem -= q1 * 365;
            y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
            m = 1;
            while (m < 12 && rem >= days_of_month(y, m)) begin
                rem -= days_of_month(y, m);
                m++;
            end
            year  = y;
            month = m;
            day   = rem + 1;
        endfunction

        function void note_command(t_date_cmd c);
            t_date_res r;
            int ty;
            int tm;
            int td;
            int cur;
            int n;
            // clamp target year, then month, then day against that month
            ty = int'(c.year);
            if (ty < 1) ty = 1;
            if (ty > 9999) ty = 9999;
            tm = int'(c.month);
            if (tm < 1) tm = 1;
            if (tm > 12) tm = 12;
            td = int'(c.day);
            if (td < 1) td = 1;
            if (td > days_of_month(ty, tm)) td = days_of_month(ty, tm);
            cur = day_number(year, month, day);
            r.interval = '0;
            r.hit      = 1'b0;
            case (c.op)
                cds_pkg::OP_LOAD: begin
                    year  = ty;
                    month = tm;
                    day   = td;
                end
                cds_pkg::OP_ADVANCE: begin
                    n = cur + int'(c.count);
                    if (n > LAST_DAY_NUMBER) begin
                        n     = LAST_DAY_NUMBER;
                        r.hit = 1'b1;
                    end
                    set_from_number(n);
                end
                cds_pkg::OP_BACK: begin
                    n = cur - int'(c.count);
                    if (n < 0) begin
                        n     = 0;
                        r.hit = 1'b1;
                    end
                    set_from_number(n);
                end
                default: r.interval = cds_pkg::IVL_W'(day_number(ty, tm, td) - cur);
            endcase
            r.year  = cds_pkg::YEAR_W'(year);
            r.month = cds_pkg::MONTH_W'(month);
            r.day   = cds_pkg::DAY_W'(day);
            pending.push_back(r);
        endfunction

        function void check_result(t_date_res got);
            t_date_res want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing pending: %0d-%0d-%0d ivl %0d hit %0b",
                         $time, got.year, got.month, got.day, got.interval, got.hit);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.year !== want.year) begin
                $display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
                errors++;
            end
            if (got.month !== want.month) begin
                $display("%0t: month expected %0d actual %0d", $time, want.month, got.month);
                errors++;
            end
            if (got.day !== want.day) begin
                $display("%0t: day expected %0d actual %0d", $time, want.day, got.day);
                errors++;
            end
            if (got.interval !== want.interval) begin
                $display("%0t: interval expected %0d actual %0d",
                         $time, want.interval, got.interval);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $display("%0t: range_hit expected %0b actual %0b", $time, want.hit, got.hit);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   recv_stall_pct;

    t_date_scoreboard board;

    cds_in_if  cmd_ch ();
    cds_out_if res_ch ();

    calendar_date_stepper DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk) begin
        res_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : collect
        t_date_res got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.year     = res_ch.current_year;
            got.month    = res_ch.current_month;
            got.day      = res_ch.current_day;
            got.interval = res_ch.day_interval;
            got.hit      = res_ch.range_hit;
            board.check_result(got);
        end
    end

    task automatic send_command(input t_date_cmd c);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid        = 1'b1;
        cmd_ch.operation    = c.op;
        cmd_ch.day_count    = c.count;
        cmd_ch.target_year  = c.year;
        cmd_ch.target_month = c.month;
        cmd_ch.target_day   = c.day;
        do @(posedge clk); while (!cmd_ch.ready);
        board.note_command(c);
    endtask

    task automatic send_op(input cds_pkg::t_op op, input int cnt, input int y, input int m,
                           input int d);
        t_date_cmd c;
        c.op    = op;
        c.count = cds_pkg::CNT_IN_W'(cnt);
        c.year  = cds_pkg::YEAR_W'(y);
        c.month = cds_pkg::MONTH_W'(m);
        c.day   = cds_pkg::DAY_W'(d);
        send_command(c);
    endtask

    // bias targets toward the year limits, century February and invalid fields
    function automatic void pick_target(output logic [cds_pkg::YEAR_W-1:0] y,
                                        output logic [cds_pkg::MONTH_W-1:0] m,
                                        output logic [cds_pkg::DAY_W-1:0] d);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            y = cds_pkg::YEAR_W'($urandom_range(9998, 9999));
            m = cds_pkg::MONTH_W'($urandom_range(10, 12));
            d = cds_pkg::DAY_W'($urandom_range(1, 31));
        end else if (kind < 45) begin
            y = cds_pkg::YEAR_W'($urandom_range(1, 2));
            m = cds_pkg::MONTH_W'($urandom_range(1, 3));
            d = cds_pkg::DAY_W'($urandom_range(1, 31));
        end else if (kind < 55) begin
            y = cds_pkg::YEAR_W'($urandom_range(0, 16383));
            m = cds_pkg::MONTH_W'($urandom_range(0, 15));
            d = cds_pkg::DAY_W'($urandom_range(0, 31));
        end else if (kind < 65) begin
            y = cds_pkg::YEAR_W'(100 * $urandom_range(1, 99));
            m = cds_pkg::MONTH_W'(2);
            d = cds_pkg::DAY_W'($urandom_range(27, 31));
        end else begin
            y = cds_pkg::YEAR_W'($urandom_range(1, 9999));
            m = cds_pkg::MONTH_W'($urandom_range(1, 12));
            d = cds_pkg::DAY_W'($urandom_range(1, 31));
        end
    endfunction

    function automatic t_date_cmd random_command(input int idx);
        t_date_cmd c;
        int roll;
        roll = $urandom_range(0, 99);
        pick_target(c.year, c.month, c.day);
        c.count = cds_pkg::CNT_IN_W'($urandom_range(0, 65535));
        // full-range steps are slow: keep them to one in a hundred
        if (idx % 100 == 50) begin
            c.op = (roll < 50) ? cds_pkg::OP_ADVANCE : cds_pkg::OP_BACK;
        end else begin
            if (roll < 20)
                c.op = cds_pkg::OP_LOAD;
            else if (roll < 50)
                c.op = cds_pkg::OP_ADVANCE;
            else if (roll < 80)
                c.op = cds_pkg::OP_BACK;
            else
                c.op = cds_pkg::OP_MEASURE;
            if (c.op == cds_pkg::OP_ADVANCE || c.op == cds_pkg::OP_BACK)
                c.count = cds_pkg::CNT_IN_W'(($urandom_range(0, 9) == 0)
                                             ? $urandom_range(0, 3)
                                             : $urandom_range(0, 600));
        end
        return c;
    endfunction

    initial begin
        #64_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        board               = new();
        sender_idle_pct     = 0;
        recv_stall_pct      = 0;
        rst_n               = 1'b0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = cds_pkg::OP_LOAD;
        cmd_ch.day_count    = '0;
        cmd_ch.target_year  = '0;
        cmd_ch.target_month = '0;
        cmd_ch.target_day   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset date, lower limit, upper limit
        send_op(cds_pkg::OP_ADVANCE, 0, 0, 0, 0);
        send_op(cds_pkg::OP_MEASURE, 0, 1901, 1, 1);
        send_op(cds_pkg::OP_LOAD, 65535, 0, 0, 0);
        send_op(cds_pkg::OP_BACK, 0, 0, 0, 0);
        send_op(cds_pkg::OP_BACK, 1, 0, 0, 0);
        send_op(cds_pkg::OP_MEASURE, 0, 16383, 15, 31);
        send_op(cds_pkg::OP_LOAD, 0, 9999, 12, 31);
        send_op(cds_pkg::OP_ADVANCE, 0, 0, 0, 0);
        send_op(cds_pkg::OP_ADVANCE, 1, 0, 0, 0);
        send_op(cds_pkg::OP_MEASURE, 65535, 0, 0, 0);
        send_op(cds_pkg::OP_LOAD, 0, 9999, 12, 1);
        send_op(cds_pkg::OP_ADVANCE, 30, 0, 0, 0);
        send_op(cds_pkg::OP_BACK, 65535, 0, 0, 0);
        send_op(cds_pkg::OP_ADVANCE, 65535, 0, 0, 0);
        send_op(cds_pkg::OP_LOAD, 0, 1, 1, 31);
        send_op(cds_pkg::OP_BACK, 30, 0, 0, 0);
        // leap rules and day clamping
        send_op(cds_pkg::OP_LOAD, 0, 2000, 2, 31);
        send_op(cds_pkg::OP_ADVANCE, 1, 0, 0, 0);
        send_op(cds_pkg::OP_BACK, 2, 0, 0, 0);
        send_op(cds_pkg::OP_LOAD, 0, 1900, 2, 29);
        send_op(cds_pkg::OP_ADVANCE, 1, 0, 0, 0);
        send_op(cds_pkg::OP_LOAD, 0, 2023, 4, 31);
        send_op(cds_pkg::OP_LOAD, 0, 2024, 13, 0);
        send_op(cds_pkg::OP_ADVANCE, 65535, 0, 0, 0);
        send_op(cds_pkg::OP_MEASURE, 0, 2024, 2, 30);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int i = 0; i < 225; i++)
                send_command(random_command(phase * 225 + i));
        end

        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
